// ===== rtl/board_temperature_aggregator_macros.svh =====
// Assertion macros for the board temperature aggregator.
`ifndef BOARD_TEMPERATURE_AGGREGATOR_MACROS_SVH
`define BOARD_TEMPERATURE_AGGREGATOR_MACROS_SVH

// Check cons in the same cycle as ante, on clk with rst_n low masking.
`define BTA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define BTA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bta_pkg.sv =====
// Shared constants and widths for the board temperature aggregator.
`default_nettype none

package bta_pkg;

    localparam int BOARD_COUNT = 8;
    localparam int IDX_W       = $clog2(BOARD_COUNT);
    localparam int CNT_W       = $clog2(BOARD_COUNT + 1);
    localparam int SUM_W       = 8 + $clog2(BOARD_COUNT);
    localparam int STEP_W      = $clog2(SUM_W);

    localparam logic signed [7:0] ERROR_FILL_TEMP = 8'sd127;
    localparam logic signed [7:0] EMPTY_MIN       = 8'sd127;
    localparam logic signed [7:0] EMPTY_MAX       = -8'sd128;

    localparam logic [3:0] FRAME_LEN_SUMMARY = 4'd4;
    localparam logic [3:0] SEEN_SAT          = 4'd15;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT_MS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_GRACE_MS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THERMISTOR_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_SENSOR_ID = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_SENSOR_ID  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_OFFSET   = 3'd6;

    localparam logic [10:0] RST_BASE_FRAME_ID    = 11'd0;
    localparam logic [15:0] RST_STALE_LIMIT_MS   = 16'd1000;
    localparam logic [15:0] RST_STARTUP_GRACE_MS = 16'd10000;

endpackage

`default_nettype wire

// ===== rtl/bta_if.sv =====
// Valid/ready channel interfaces for command items and report items.
`default_nettype none

interface bta_cmd_if import bta_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [31:0]        now_ms;
    logic [10:0]        frame_id;
    logic [3:0]         frame_len;
    logic [7:0]         board_byte;
    logic signed [7:0]  frame_min;
    logic signed [7:0]  frame_max;
    logic signed [7:0]  frame_avg;

    modport source (
        output valid, opcode, now_ms, frame_id, frame_len, board_byte,
               frame_min, frame_max, frame_avg,
        input  ready
    );
    modport sink (
        input  valid, opcode, now_ms, frame_id, frame_len, board_byte,
               frame_min, frame_max, frame_avg,
        output ready
    );
endinterface

interface bta_rpt_if import bta_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [7:0]  global_min;
    logic signed [7:0]  global_max;
    logic signed [7:0]  global_avg;
    logic               timeout_flag;
    logic [3:0]         seen_count;
    logic [7:0]         report_checksum;

    modport source (
        output valid, global_min, global_max, global_avg, timeout_flag,
               seen_count, report_checksum,
        input  ready
    );
    modport sink (
        input  valid, global_min, global_max, global_avg, timeout_flag,
               seen_count, report_checksum,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/board_temperature_aggregator.sv =====
// Top level of the board temperature aggregator: board table, evaluate sequencer, report.
`default_nettype none

// A frame item is checked and stored in the cycle it is accepted, and the block
// is ready again at once. An evaluate item occupies the block: the sequencer
// reads one table entry per cycle through a single compare/accumulate unit,
// then a restoring divider produces one quotient bit per cycle for the mean,
// and a final state applies the timeout fill and the checksum. The report waits
// in an output register, so frames are taken while it is not yet collected; the
// next evaluate stalls in its final state until the previous report has been
// taken.
module board_temperature_aggregator
    import bta_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    bta_cmd_if.sink                   cmd,
    bta_rpt_if.source                 rpt
);

`include "board_temperature_aggregator_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_ABS,
        ST_DIV,
        ST_FIN
    } state_t;

    // configuration
    logic [10:0] base_frame_id_reg;
    logic [15:0] stale_limit_ms_reg;
    logic [15:0] startup_grace_ms_reg;
    logic [7:0]  thermistor_count_reg;
    logic [7:0]  highest_sensor_id_reg;
    logic [7:0]  lowest_sensor_id_reg;
    logic [7:0]  checksum_offset_reg;

    // board table
    logic signed [7:0] board_min_reg  [BOARD_COUNT];
    logic signed [7:0] board_max_reg  [BOARD_COUNT];
    logic signed [7:0] board_mean_reg [BOARD_COUNT];
    logic [31:0]       board_stamp_reg[BOARD_COUNT];
    logic [BOARD_COUNT-1:0] board_seen_reg;

    // sequencer
    state_t state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [31:0]             now_reg, now_next;
    logic signed [7:0]       gmin_reg, gmin_next;
    logic signed [7:0]       gmax_reg, gmax_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    tmo_reg, tmo_next;
    logic                    neg_reg, neg_next;
    logic [SUM_W-1:0]        mag_reg, mag_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [STEP_W-1:0]       step_reg, step_next;

    // report register
    logic              rpt_valid_reg, rpt_valid_next;
    logic signed [7:0] rpt_min_reg, rpt_min_next;
    logic signed [7:0] rpt_max_reg, rpt_max_next;
    logic signed [7:0] rpt_avg_reg, rpt_avg_next;
    logic              rpt_tmo_reg, rpt_tmo_next;
    logic [3:0]        rpt_seen_reg, rpt_seen_next;
    logic [7:0]        rpt_csum_reg, rpt_csum_next;

    logic cmd_fire;
    logic rpt_free;

    // frame check
    logic [11:0] id_ext;
    logic [11:0] base_ext;
    logic [11:0] base_top;
    logic [10:0] slot_full;
    logic        frame_ok;
    logic [IDX_W-1:0] slot;

    // walk datapath
    logic              ent_seen;
    logic signed [7:0] ent_min;
    logic signed [7:0] ent_max;
    logic signed [7:0] ent_mean;
    logic [31:0]       ent_age;
    logic              ent_tmo;

    // divider datapath
    logic [CNT_W:0]    rem_shift;
    logic              rem_ge;
    logic [CNT_W:0]    rem_sub;

    // finish datapath
    logic [7:0]        quo_byte;
    logic signed [7:0] avg_raw;
    logic signed [7:0] fin_min;
    logic signed [7:0] fin_max;
    logic signed [7:0] fin_avg;
    logic [7:0]        cnt_wide;
    logic [3:0]        seen_sat;
    logic [7:0]        fin_csum;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign rpt_free  = !rpt_valid_reg || rpt.ready;

    assign rpt.valid           = rpt_valid_reg;
    assign rpt.global_min      = rpt_min_reg;
    assign rpt.global_max      = rpt_max_reg;
    assign rpt.global_avg      = rpt_avg_reg;
    assign rpt.timeout_flag    = rpt_tmo_reg;
    assign rpt.seen_count      = rpt_seen_reg;
    assign rpt.report_checksum = rpt_csum_reg;

    // frame address, length and board-byte check
    assign id_ext    = {1'b0, cmd.frame_id};
    assign base_ext  = {1'b0, base_frame_id_reg};
    assign base_top  = base_ext + 12'(BOARD_COUNT);
    assign slot_full = cmd.frame_id - base_frame_id_reg;
    assign slot      = slot_full[IDX_W-1:0];
    assign frame_ok  = (id_ext >= base_ext) && (id_ext < base_top)
                     && (cmd.frame_len == FRAME_LEN_SUMMARY)
                     && (slot_full == {3'b000, cmd.board_byte});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_frame_id_reg     <= RST_BASE_FRAME_ID;
            stale_limit_ms_reg    <= RST_STALE_LIMIT_MS;
            startup_grace_ms_reg  <= RST_STARTUP_GRACE_MS;
            thermistor_count_reg  <= 8'd0;
            highest_sensor_id_reg <= 8'd0;
            lowest_sensor_id_reg  <= 8'd0;
            checksum_offset_reg   <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_FRAME_ID:     base_frame_id_reg     <= cfg_data[10:0];
                CFG_STALE_LIMIT_MS:    stale_limit_ms_reg    <= cfg_data[15:0];
                CFG_STARTUP_GRACE_MS:  startup_grace_ms_reg  <= cfg_data[15:0];
                CFG_THERMISTOR_COUNT:  thermistor_count_reg  <= cfg_data[7:0];
                CFG_HIGHEST_SENSOR_ID: highest_sensor_id_reg <= cfg_data[7:0];
                CFG_LOWEST_SENSOR_ID:  lowest_sensor_id_reg  <= cfg_data[7:0];
                CFG_CHECKSUM_OFFSET:   checksum_offset_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_seen_reg <= '0;
        end
        else if (cmd_fire && cmd.opcode == OP_FRAME && frame_ok)
        begin
            board_seen_reg[slot] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire && cmd.opcode == OP_FRAME && frame_ok)
        begin
            board_min_reg[slot]   <= cmd.frame_min;
            board_max_reg[slot]   <= cmd.frame_max;
            board_mean_reg[slot]  <= cmd.frame_avg;
            board_stamp_reg[slot] <= cmd.now_ms;
        end
    end

    // one table entry per walk step
    assign ent_seen = board_seen_reg[idx_reg];
    assign ent_min  = board_min_reg[idx_reg];
    assign ent_max  = board_max_reg[idx_reg];
    assign ent_mean = board_mean_reg[idx_reg];
    assign ent_age  = now_reg - board_stamp_reg[idx_reg];
    assign ent_tmo  = (idx_reg != '0)
                    && (ent_seen ? (ent_age > {16'd0, stale_limit_ms_reg})
                                 : (now_reg > {16'd0, startup_grace_ms_reg}));

    // restoring divide step
    assign rem_shift = {rem_reg, mag_reg[SUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, cnt_reg};
    assign rem_sub   = rem_shift - {1'b0, cnt_reg};

    // finish: sign, fill, checksum
    assign quo_byte = mag_reg[7:0];
    assign avg_raw  = (cnt_reg == '0) ? 8'sd0
                    : (neg_reg ? -$signed(quo_byte) : $signed(quo_byte));
    assign fin_min  = tmo_reg ? ERROR_FILL_TEMP : gmin_reg;
    assign fin_max  = tmo_reg ? ERROR_FILL_TEMP : gmax_reg;
    assign fin_avg  = tmo_reg ? ERROR_FILL_TEMP : avg_raw;
    assign cnt_wide = 8'(cnt_reg);
    assign seen_sat = (cnt_wide > 8'(SEEN_SAT)) ? SEEN_SAT : cnt_wide[3:0];
    assign fin_csum = $unsigned(fin_min) + $unsigned(fin_max) + $unsigned(fin_avg)
                    + thermistor_count_reg + highest_sensor_id_reg
                    + lowest_sensor_id_reg + checksum_offset_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        now_next       = now_reg;
        gmin_next      = gmin_reg;
        gmax_next      = gmax_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        tmo_next       = tmo_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        rpt_valid_next = rpt_valid_reg && !rpt.ready;
        rpt_min_next   = rpt_min_reg;
        rpt_max_next   = rpt_max_reg;
        rpt_avg_next   = rpt_avg_reg;
        rpt_tmo_next   = rpt_tmo_reg;
        rpt_seen_next  = rpt_seen_reg;
        rpt_csum_next  = rpt_csum_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && cmd.opcode == OP_EVAL)
                begin
                    state_next = ST_WALK;
                    idx_next   = '0;
                    now_next   = cmd.now_ms;
                    gmin_next  = EMPTY_MIN;
                    gmax_next  = EMPTY_MAX;
                    sum_next   = '0;
                    cnt_next   = '0;
                    tmo_next   = 1'b0;
                end
            end
            ST_WALK:
            begin
                if (ent_tmo)
                begin
                    tmo_next = 1'b1;
                end
                if (ent_seen)
                begin
                    if (ent_min < gmin_reg)
                    begin
                        gmin_next = ent_min;
                    end
                    if (ent_max > gmax_reg)
                    begin
                        gmax_next = ent_max;
                    end
                    sum_next = sum_reg + SUM_W'(ent_mean);
                    cnt_next = cnt_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(BOARD_COUNT - 1))
                begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS:
            begin
                neg_next   = sum_reg[SUM_W-1];
                mag_next   = sum_reg[SUM_W-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);
                rem_next   = '0;
                step_next  = STEP_W'(SUM_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = rem_ge ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
                mag_next  = {mag_reg[SUM_W-2:0], rem_ge};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (rpt_free)
                begin
                    rpt_valid_next = 1'b1;
                    rpt_min_next   = fin_min;
                    rpt_max_next   = fin_max;
                    rpt_avg_next   = fin_avg;
                    rpt_tmo_next   = tmo_reg;
                    rpt_seen_next  = seen_sat;
                    rpt_csum_next  = fin_csum;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            step_reg      <= '0;
            rpt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            rpt_valid_reg <= rpt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        gmin_reg     <= gmin_next;
        gmax_reg     <= gmax_next;
        sum_reg      <= sum_next;
        cnt_reg      <= cnt_next;
        tmo_reg      <= tmo_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        rem_reg      <= rem_next;
        rpt_min_reg  <= rpt_min_next;
        rpt_max_reg  <= rpt_max_next;
        rpt_avg_reg  <= rpt_avg_next;
        rpt_tmo_reg  <= rpt_tmo_next;
        rpt_seen_reg <= rpt_seen_next;
        rpt_csum_reg <= rpt_csum_next;
    end

    `BTA_ASSERT_SAME(a_fill_on_timeout, rpt.valid && rpt.timeout_flag, rpt.global_min == ERROR_FILL_TEMP && rpt.global_max == ERROR_FILL_TEMP && rpt.global_avg == ERROR_FILL_TEMP, "timeout report without fill values")
    `BTA_ASSERT_SAME(a_empty_report, rpt.valid && !rpt.timeout_flag && rpt.seen_count == 4'd0, rpt.global_min == EMPTY_MIN && rpt.global_max == EMPTY_MAX && rpt.global_avg == 8'sd0, "empty report has wrong temperatures")
    `BTA_ASSERT_NEXT(a_eval_busy, cmd.valid && cmd.ready && cmd.opcode == OP_EVAL, !cmd.ready && state_reg == ST_WALK, "evaluate item did not start the table walk")
    `BTA_ASSERT_NEXT(a_walk_to_div, state_reg == ST_ABS, state_reg == ST_DIV && step_reg == STEP_W'(SUM_W - 1), "divider not started after walk")

endmodule

`default_nettype wire

// ===== tb/board_temperature_aggregator_test.sv =====
// Self-checking testbench for the board temperature aggregator: directed table, then random phases.
`default_nettype none

module board_temperature_aggregator_test
    import bta_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 94;
    localparam int SETTLE_CYCLES = 2 * (BOARD_COUNT + SUM_W + 3);
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_PRINTS    = 50;

    typedef struct packed {
        logic              opcode;
        logic [31:0]       now_ms;
        logic [10:0]       frame_id;
        logic [3:0]        frame_len;
        logic [7:0]        board_byte;
        logic signed [7:0] frame_min;
        logic signed [7:0] frame_max;
        logic signed [7:0] frame_avg;
    } cmd_item_t;

    typedef struct packed {
        logic signed [7:0] global_min;
        logic signed [7:0] global_max;
        logic signed [7:0] global_avg;
        logic              timeout_flag;
        logic [3:0]        seen_count;
        logic [7:0]        report_checksum;
    } report_t;

    typedef struct packed {
        cmd_item_t item;
        bit        typed;
        report_t   want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    bta_cmd_if cmd ();
    bta_rpt_if rpt ();

    board_temperature_aggregator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .rpt       (rpt)
    );

    always #1 clk = ~clk;

    int unsigned base_id    = RST_BASE_FRAME_ID;
    logic [15:0] stale_ms   = RST_STALE_LIMIT_MS;
    logic [15:0] grace_ms   = RST_STARTUP_GRACE_MS;
    logic [7:0]  therm_byte = 8'd0;
    logic [7:0]  high_byte  = 8'd0;
    logic [7:0]  low_byte   = 8'd0;
    logic [7:0]  offset_byte = 8'd0;

    logic signed [7:0] tbl_min   [BOARD_COUNT];
    logic signed [7:0] tbl_max   [BOARD_COUNT];
    logic signed [7:0] tbl_mean  [BOARD_COUNT];
    logic [31:0]       tbl_stamp [BOARD_COUNT];
    bit                tbl_seen  [BOARD_COUNT] = '{default: 1'b0};

    report_t   reports_due [$];
    plan_row_t plan [$];

    int errors = 0;
    int frames_stored = 0;
    int frames_dropped = 0;
    int evaluations = 0;
    int timeouts = 0;
    int settings_used = 1;
    bit calm = 1'b0;
    logic [31:0] clock_ms = 32'd0;
    int unsigned step_max = 100;

    task automatic note_mismatch(string what, int got, int want);
        if (errors < MAX_PRINTS)
            $display("mismatch %s: got %0d, want %0d", what, got, want);
        errors++;
    endtask

    function automatic bit aggregate_item(input cmd_item_t it, output report_t r);
        int unsigned slot;
        bit late;
        int lo, hi, total, seen, mean;
        logic [31:0] age;
        r = '0;
        if (it.opcode == OP_FRAME)
        begin
            slot = it.frame_id - base_id;
            if (it.frame_id < base_id || it.frame_id >= base_id + BOARD_COUNT
                || it.frame_len != FRAME_LEN_SUMMARY || slot != it.board_byte)
            begin
                frames_dropped++;
                return 1'b0;
            end
            tbl_min[slot]   = it.frame_min;
            tbl_max[slot]   = it.frame_max;
            tbl_mean[slot]  = it.frame_avg;
            tbl_stamp[slot] = it.now_ms;
            tbl_seen[slot]  = 1'b1;
            frames_stored++;
            return 1'b0;
        end
        late = 1'b0;
        for (int i = 1; i < BOARD_COUNT; i++)
        begin
            age = it.now_ms - tbl_stamp[i];
            if (!tbl_seen[i])
            begin
                if (it.now_ms > grace_ms)
                    late = 1'b1;
            end
            else if (age > stale_ms)
                late = 1'b1;
        end
        lo = EMPTY_MIN;
        hi = EMPTY_MAX;
        total = 0;
        seen = 0;
        for (int i = 0; i < BOARD_COUNT; i++)
        begin
            if (tbl_seen[i])
            begin
                if (tbl_min[i] < lo)
                    lo = tbl_min[i];
                if (tbl_max[i] > hi)
                    hi = tbl_max[i];
                total += tbl_mean[i];
                seen++;
            end
        end
        mean = (seen > 0) ? total / seen : 0;
        if (late)
        begin
            lo = ERROR_FILL_TEMP;
            hi = ERROR_FILL_TEMP;
            mean = ERROR_FILL_TEMP;
            timeouts++;
        end
        evaluations++;
        r.global_min      = lo[7:0];
        r.global_max      = hi[7:0];
        r.global_avg      = mean[7:0];
        r.timeout_flag    = late;
        r.seen_count      = (seen > SEEN_SAT) ? SEEN_SAT : 4'(seen);
        r.report_checksum = 8'(lo[7:0] + hi[7:0] + mean[7:0] + therm_byte + high_byte
                              + low_byte + offset_byte);
        return 1'b1;
    endfunction

    function automatic cmd_item_t frame_at(logic [31:0] now, logic [10:0] id,
                                           logic [3:0] len, logic [7:0] bb,
                                           logic signed [7:0] lo, logic signed [7:0] hi,
                                           logic signed [7:0] mean);
        cmd_item_t it;
        it.opcode     = OP_FRAME;
        it.now_ms     = now;
        it.frame_id   = id;
        it.frame_len  = len;
        it.board_byte = bb;
        it.frame_min  = lo;
        it.frame_max  = hi;
        it.frame_avg  = mean;
        return it;
    endfunction

    function automatic cmd_item_t eval_at(logic [31:0] now);
        cmd_item_t it;
        it.opcode     = OP_EVAL;
        it.now_ms     = now;
        it.frame_id   = 11'($urandom);
        it.frame_len  = 4'($urandom);
        it.board_byte = 8'($urandom);
        it.frame_min  = 8'($urandom);
        it.frame_max  = 8'($urandom);
        it.frame_avg  = 8'($urandom);
        return it;
    endfunction

    function automatic void add_row(cmd_item_t it, bit typed = 1'b0, report_t want = '0);
        plan_row_t row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endfunction

    function automatic cmd_item_t draw_item(output bit counts);
        cmd_item_t it;
        int unsigned pick, slot;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, step_max);
        slot = $urandom_range(0, BOARD_COUNT - 1);
        if (base_id + slot > 11'h7FF)
            slot = 0;
        it = frame_at(clock_ms, 11'(base_id + slot), FRAME_LEN_SUMMARY, 8'(slot),
                      8'($urandom), 8'($urandom), 8'($urandom));
        counts = 1'b1;
        if (pick < 12)
        begin
            it = eval_at($urandom);
            it.opcode    = 1'($urandom);
            it.frame_len = 4'($urandom_range(0, 15));
            counts = 1'b0;
        end
        else if (pick < 20)
        begin
            counts = 1'b0;
            case ($urandom_range(0, 3))
                0: it.frame_len = FRAME_LEN_SUMMARY ^ 4'($urandom_range(1, 15));
                1: it.board_byte = it.board_byte ^ 8'($urandom_range(1, 255));
                2: it.frame_id = 11'(base_id - 1);
                default: it.frame_id = 11'(base_id + BOARD_COUNT);
            endcase
        end
        else if (pick >= 68)
            it = eval_at(clock_ms);
        return it;
    endfunction

    task automatic send_cmd(cmd_item_t it, bit typed, report_t want);
        report_t predicted;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.opcode     <= it.opcode;
        cmd.now_ms     <= it.now_ms;
        cmd.frame_id   <= it.frame_id;
        cmd.frame_len  <= it.frame_len;
        cmd.board_byte <= it.board_byte;
        cmd.frame_min  <= it.frame_min;
        cmd.frame_max  <= it.frame_max;
        cmd.frame_avg  <= it.frame_avg;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        if (aggregate_item(it, predicted))
            reports_due.push_back(typed ? want : predicted);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_BASE_FRAME_ID:     base_id = value[10:0];
            CFG_STALE_LIMIT_MS:    stale_ms = value;
            CFG_STARTUP_GRACE_MS:  grace_ms = value;
            CFG_THERMISTOR_COUNT:  therm_byte = value[7:0];
            CFG_HIGHEST_SENSOR_ID: high_byte = value[7:0];
            CFG_LOWEST_SENSOR_ID:  low_byte = value[7:0];
            CFG_CHECKSUM_OFFSET:   offset_byte = value[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [CFG_W-1:0] base, logic [CFG_W-1:0] stale,
                                  logic [CFG_W-1:0] grace, logic [CFG_W-1:0] therm,
                                  logic [CFG_W-1:0] high_id, logic [CFG_W-1:0] low_id,
                                  logic [CFG_W-1:0] offset);
        write_reg(CFG_BASE_FRAME_ID, base);
        write_reg(CFG_STALE_LIMIT_MS, stale);
        write_reg(CFG_STARTUP_GRACE_MS, grace);
        write_reg(CFG_THERMISTOR_COUNT, therm);
        write_reg(CFG_HIGHEST_SENSOR_ID, high_id);
        write_reg(CFG_LOWEST_SENSOR_ID, low_id);
        write_reg(CFG_CHECKSUM_OFFSET, offset);
        write_reg(CFG_NONE, CFG_W'($urandom));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd.valid && cmd.ready) || (rpt.valid && rpt.ready) || cfg_we)
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int hold;
        report_t want, got;
        hold = 0;
        rpt.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rpt.valid && rpt.ready)
            begin
                got.global_min      = rpt.global_min;
                got.global_max      = rpt.global_max;
                got.global_avg      = rpt.global_avg;
                got.timeout_flag    = rpt.timeout_flag;
                got.seen_count      = rpt.seen_count;
                got.report_checksum = rpt.report_checksum;
                if (reports_due.size() == 0)
                    note_mismatch("report with none pending", got.report_checksum, 0);
                else
                begin
                    want = reports_due.pop_front();
                    if (got.global_min !== want.global_min)
                        note_mismatch("global_min", got.global_min, want.global_min);
                    if (got.global_max !== want.global_max)
                        note_mismatch("global_max", got.global_max, want.global_max);
                    if (got.global_avg !== want.global_avg)
                        note_mismatch("global_avg", got.global_avg, want.global_avg);
                    if (got.timeout_flag !== want.timeout_flag)
                        note_mismatch("timeout_flag", got.timeout_flag, want.timeout_flag);
                    if (got.seen_count !== want.seen_count)
                        note_mismatch("seen_count", got.seen_count, want.seen_count);
                    if (got.report_checksum !== want.report_checksum)
                        note_mismatch("report_checksum", got.report_checksum,
                                      want.report_checksum);
                end
            end
            if (hold > 0)
            begin
                rpt.ready <= 1'b0;
                hold--;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                rpt.ready <= 1'b0;
                hold = $urandom_range(0, 2);
            end
            else
                rpt.ready <= 1'b1;
        end
    end

    initial
    begin
        int counted;
        bit counts;
        cmd_item_t it;
        cmd.valid      <= 1'b0;
        cmd.opcode     <= OP_FRAME;
        cmd.now_ms     <= '0;
        cmd.frame_id   <= '0;
        cmd.frame_len  <= '0;
        cmd.board_byte <= '0;
        cmd.frame_min  <= '0;
        cmd.frame_max  <= '0;
        cmd.frame_avg  <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(eval_at(32'd0), 1'b1, '{8'sd127, -8'sd128, 8'sd0, 1'b0, 4'd0, 8'hFF});
        add_row(eval_at(32'd10000), 1'b1, '{8'sd127, -8'sd128, 8'sd0, 1'b0, 4'd0, 8'hFF});
        add_row(eval_at(32'd10001), 1'b1, '{8'sd127, 8'sd127, 8'sd127, 1'b1, 4'd0, 8'h7D});
        add_row(eval_at(32'hFFFF_FFFF), 1'b1,
                '{8'sd127, 8'sd127, 8'sd127, 1'b1, 4'd0, 8'h7D});
        add_row(frame_at(32'd5, 11'd0, 4'd4, 8'd0, -8'sd128, 8'sd127, -8'sd128));
        add_row(eval_at(32'd6), 1'b1, '{-8'sd128, 8'sd127, -8'sd128, 1'b0, 4'd1, 8'h7F});
        add_row(frame_at(32'd7, 11'd1, 4'd15, 8'd1, 8'sd1, 8'sd1, 8'sd1));
        add_row(frame_at(32'd7, 11'd1, 4'd8, 8'd1, 8'sd1, 8'sd1, 8'sd1));
        add_row(frame_at(32'd7, 11'd1, 4'd0, 8'd1, 8'sd1, 8'sd1, 8'sd1));
        add_row(frame_at(32'd7, 11'd1, 4'd4, 8'd2, 8'sd1, 8'sd1, 8'sd1));
        add_row(frame_at(32'd7, 11'd8, 4'd4, 8'd8, 8'sd1, 8'sd1, 8'sd1));
        add_row(frame_at(32'd7, 11'd2047, 4'd4, 8'd255, 8'sd1, 8'sd1, 8'sd1));
        add_row(eval_at(32'd8), 1'b1, '{-8'sd128, 8'sd127, -8'sd128, 1'b0, 4'd1, 8'h7F});
        add_row(frame_at(32'd100, 11'd1, 4'd4, 8'd1, 8'sd127, 8'sd127, 8'sd127));
        add_row(frame_at(32'd100, 11'd2, 4'd4, 8'd2, -8'sd1, 8'sd5, -8'sd1));
        add_row(frame_at(32'd100, 11'd3, 4'd4, 8'd3, -8'sd20, -8'sd3, -8'sd7));
        add_row(frame_at(32'd100, 11'd4, 4'd4, 8'd4, 8'sd0, 8'sd10, 8'sd3));
        add_row(frame_at(32'd100, 11'd5, 4'd4, 8'd5, -8'sd100, -8'sd40, -8'sd50));
        add_row(frame_at(32'd100, 11'd6, 4'd4, 8'd6, 8'sd1, 8'sd2, 8'sd0));
        add_row(frame_at(32'd100, 11'd7, 4'd4, 8'd7, 8'sd15, 8'sd90, 8'sd20));
        add_row(eval_at(32'd1100));
        add_row(eval_at(32'd1101), 1'b1, '{8'sd127, 8'sd127, 8'sd127, 1'b1, 4'd8, 8'h7D});
        add_row(frame_at(32'hFFFF_FFF0, 11'd3, 4'd4, 8'd3, 8'sd9, 8'sd9, 8'sd9));
        add_row(eval_at(32'd5));
        foreach (plan[k])
            send_cmd(plan[k].item, plan[k].typed, plan[k].want);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 16'hFFFF);
                1: apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                  16'h0000, 16'h0000);
                default: apply_settings(
                    {5'($urandom), ($urandom_range(0, 3) == 0) ?
                        11'($urandom_range(2040, 2047)) : 11'($urandom_range(0, 2039))},
                    ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                        16'($urandom_range(50, 3000)),
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
            endcase
            calm = (p == PHASES - 1);
            clock_ms = $urandom_range(0, 70000);
            step_max = $urandom_range(1, 300);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                it = draw_item(counts);
                send_cmd(it, 1'b0, '0);
                if (counts)
                    counted++;
            end
        end
        drain();

        if (reports_due.size() != 0)
            note_mismatch("reports never delivered", 0, reports_due.size());
        $display("covered %0d stored frames, %0d dropped frames, %0d evaluations",
                 frames_stored, frames_dropped, evaluations);
        $display("%0d evaluations timed out, across %0d register settings",
                 timeouts, settings_used);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/bta_pkg.sv
rtl/bta_if.sv
rtl/board_temperature_aggregator.sv
tb/board_temperature_aggregator_test.sv
